### hw/rtl/rhsp_pkg.sv
// ----------------------------------------------------------------------------
// rhsp_pkg: record header stream parser shared definitions
// Parse phases, byte classes, register indexes and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsp_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DLEN_W     = 56;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEW_NAME_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_MASK      = 1'b1;

  localparam logic [7:0] NEW_NAME_MASK_RST = 8'h01;
  localparam logic [7:0] EXT_MASK_RST      = 8'h02;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_NAME    = 3'd2,
    PH_STAMP   = 3'd3,
    PH_HIGH    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CLS_TYPE    = 3'd0,
    CLS_NAME_LEN = 3'd1,
    CLS_NAME    = 3'd2,
    CLS_STAMP   = 3'd3,
    CLS_HIGH    = 3'd4,
    CLS_PAY_LEN = 3'd5,
    CLS_PAYLOAD = 3'd6
  } byte_class_t;

  typedef struct packed {
    byte_class_t        byte_class;
    logic [7:0]         byte_value;
    logic [15:0]        record_type;
    logic [31:0]        stamp;
    logic [DLEN_W-1:0]  decoded_length;
    logic               length_complete;
    logic               end_of_name;
    logic               end_of_record;
    logic               bad_length;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/rhsp_parser.sv
// ----------------------------------------------------------------------------
// rhsp_parser: per-byte parse state and classification
// Holds the record parse state, classifies one byte per step and advances.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsp_parser #(
  parameter int unsigned MAX_LEN_BYTES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          data,
  input  wire logic [7:0]          new_name_mask,
  input  wire logic [7:0]          ext_mask,
  output rhsp_pkg::result_t        res
);

  // a code of n bytes carries 7*n value bits
  localparam int unsigned LEN_W = 7 * MAX_LEN_BYTES;
  localparam int unsigned CNT_W = (MAX_LEN_BYTES > 1) ? $clog2(MAX_LEN_BYTES) : 1;

  rhsp_pkg::phase_t   phase, phase_next;
  logic [CNT_W-1:0]   len_left, len_left_next;
  logic [LEN_W-1:0]   len_acc, len_acc_next;
  logic [LEN_W-1:0]   field_left, field_left_next;
  logic [15:0]        cur_type, cur_type_next;
  logic [31:0]        cur_stamp, cur_stamp_next;
  logic [1:0]         stamp_idx, stamp_idx_next;
  logic               len_is_payload, len_is_payload_next;

  // first-byte decode: position of the marker bit
  logic [2:0]         lz;
  logic               marker_found;
  logic               first_bad;
  logic [7:0]         first_val;
  logic [LEN_W+7:0]   acc_shift;
  logic [LEN_W-1:0]   field_dec;
  logic [CNT_W-1:0]   left_dec;

  always_comb begin
    lz = 3'd0;
    marker_found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!marker_found && data[i]) begin
        lz = 3'(7 - i);
        marker_found = 1'b1;
      end
    end
    first_bad = !marker_found || ({1'b0, lz} >= 4'(MAX_LEN_BYTES));
    first_val = data & ~(8'h80 >> lz);
    acc_shift = {len_acc, data};
    field_dec = field_left - LEN_W'(1);
    left_dec  = len_left - CNT_W'(1);
  end

  always_comb begin
    logic done_len;
    logic go_ext;
    done_len            = 1'b0;
    go_ext              = 1'b0;
    phase_next          = phase;
    len_left_next       = len_left;
    len_acc_next        = len_acc;
    field_left_next     = field_left;
    cur_type_next       = cur_type;
    cur_stamp_next      = cur_stamp;
    stamp_idx_next      = stamp_idx;
    len_is_payload_next = len_is_payload;

    res.byte_class      = rhsp_pkg::CLS_TYPE;
    res.byte_value      = data;
    res.decoded_length  = '0;
    res.length_complete = 1'b0;
    res.end_of_name     = 1'b0;
    res.end_of_record   = 1'b0;
    res.bad_length      = 1'b0;

    case (phase)
      rhsp_pkg::PH_LEN: begin
        res.byte_class = len_is_payload ? rhsp_pkg::CLS_PAY_LEN : rhsp_pkg::CLS_NAME_LEN;
        if (len_left == '0) begin
          if (first_bad) begin
            res.bad_length = 1'b1;
            phase_next     = rhsp_pkg::PH_TYPE;
            len_acc_next   = '0;
          end else begin
            len_acc_next  = LEN_W'(first_val);
            len_left_next = CNT_W'(lz);
            done_len      = (lz == 3'd0);
          end
        end else begin
          len_acc_next  = acc_shift[LEN_W-1:0];
          len_left_next = left_dec;
          done_len      = (left_dec == '0);
        end
        if (done_len) begin
          res.length_complete = 1'b1;
          res.decoded_length  = rhsp_pkg::DLEN_W'(len_acc_next);
          field_left_next     = len_acc_next;
          if (len_is_payload) begin
            if (len_acc_next == '0) begin
              res.end_of_record = 1'b1;
              phase_next        = rhsp_pkg::PH_TYPE;
            end else begin
              phase_next = rhsp_pkg::PH_PAYLOAD;
            end
          end else if (len_acc_next == '0) begin
            res.end_of_name = 1'b1;
            go_ext          = 1'b1;
          end else begin
            phase_next = rhsp_pkg::PH_NAME;
          end
        end
      end
      rhsp_pkg::PH_NAME: begin
        res.byte_class  = rhsp_pkg::CLS_NAME;
        field_left_next = field_dec;
        if (field_dec == '0) begin
          res.end_of_name = 1'b1;
          go_ext          = 1'b1;
        end
      end
      rhsp_pkg::PH_STAMP: begin
        res.byte_class = rhsp_pkg::CLS_STAMP;
        cur_stamp_next[{stamp_idx, 3'b000} +: 8] = data;
        if (stamp_idx == 2'd3) begin
          stamp_idx_next = 2'd0;
          phase_next     = rhsp_pkg::PH_HIGH;
        end else begin
          stamp_idx_next = stamp_idx + 2'd1;
        end
      end
      rhsp_pkg::PH_HIGH: begin
        res.byte_class      = rhsp_pkg::CLS_HIGH;
        cur_type_next       = {data, cur_type[7:0]};
        phase_next          = rhsp_pkg::PH_LEN;
        len_is_payload_next = 1'b1;
        len_left_next       = '0;
      end
      rhsp_pkg::PH_PAYLOAD: begin
        res.byte_class  = rhsp_pkg::CLS_PAYLOAD;
        field_left_next = field_dec;
        if (field_dec == '0) begin
          res.end_of_record = 1'b1;
          phase_next        = rhsp_pkg::PH_TYPE;
        end
      end
      default: begin
        // type byte: drop the new-name bits, clear the high byte
        res.byte_class = rhsp_pkg::CLS_TYPE;
        cur_type_next  = {8'h00, data & ~new_name_mask};
        len_left_next  = '0;
        if ((data & new_name_mask) != 8'h00) begin
          phase_next          = rhsp_pkg::PH_LEN;
          len_is_payload_next = 1'b0;
        end else begin
          go_ext = 1'b1;
        end
      end
    endcase

    // name field done (or absent): timestamp block or payload length
    if (go_ext) begin
      if ((cur_type_next[7:0] & ext_mask) != 8'h00) begin
        phase_next     = rhsp_pkg::PH_STAMP;
        stamp_idx_next = 2'd0;
      end else begin
        phase_next          = rhsp_pkg::PH_LEN;
        len_is_payload_next = 1'b1;
        len_left_next       = '0;
      end
    end

    res.record_type = cur_type_next;
    res.stamp       = cur_stamp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rhsp_pkg::PH_TYPE;
      len_left       <= '0;
      len_acc        <= '0;
      field_left     <= '0;
      cur_type       <= '0;
      cur_stamp      <= '0;
      stamp_idx      <= '0;
      len_is_payload <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      len_left       <= len_left_next;
      len_acc        <= len_acc_next;
      field_left     <= field_left_next;
      cur_type       <= cur_type_next;
      cur_stamp      <= cur_stamp_next;
      stamp_idx      <= stamp_idx_next;
      len_is_payload <= len_is_payload_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/record_header_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// record_header_stream_parser_unit: byte-stream record header parser
// Classifies each byte of a decompressed record stream and reports the
// record type, timestamp, decoded length codes and field boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one stream byte per item on
//   data_byte. Output channel out_valid/out_ready returns exactly one result
//   item per input byte, in order: its class, the byte itself, the current
//   record type and timestamp, and the length/boundary flags.
//   Path: an accepted item is captured in the input register, and its result
//   is loaded into the output register when that one is empty or draining.
//   Throughput: one item per cycle while out_ready stays high. The per-byte
//   state update in the parser is a single pass of short logic; the wide
//   paths are the 56-bit field counter decrement and the 56-bit zero tests.
//   Stalls: while out_ready is low the output register holds its item; the
//   input register still fills, so one more item is taken before in_ready
//   drops. Nothing is lost or repeated.
//   Configuration: cfg_write_en writes cfg_data into the register chosen by
//   cfg_index (0 new-name mask, 1 extended mask) at that edge; write only
//   while the block is idle.
//   Reset (rst, synchronous): empties both registers, restores the masks to
//   their defaults and returns the parser to waiting for a type byte.
// ----------------------------------------------------------------------------
`default_nettype none

module record_header_stream_parser_unit #(
  parameter int unsigned MAX_LEN_BYTES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_write_en,
  input  wire logic [rhsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rhsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        data_byte,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             byte_class,
  output logic [7:0]                             byte_value,
  output logic [15:0]                            record_type,
  output logic [31:0]                            stamp,
  output logic [rhsp_pkg::DLEN_W-1:0]            decoded_length,
  output logic                                   length_complete,
  output logic                                   end_of_name,
  output logic                                   end_of_record,
  output logic                                   bad_length
);

  logic [7:0]        new_name_mask_q;
  logic [7:0]        ext_mask;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              advance;

  rhsp_pkg::result_t step_res;
  rhsp_pkg::result_t out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      new_name_mask_q <= rhsp_pkg::NEW_NAME_MASK_RST;
      ext_mask        <= rhsp_pkg::EXT_MASK_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        rhsp_pkg::REG_NEW_NAME_MASK: new_name_mask_q <= cfg_data;
        rhsp_pkg::REG_EXT_MASK:      ext_mask        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input register into the output register whenever the
  // output register is empty or being drained this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
    end
  end

  rhsp_parser #(
    .MAX_LEN_BYTES (MAX_LEN_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data          (s1_byte),
    .new_name_mask (new_name_mask_q),
    .ext_mask      (ext_mask),
    .res           (step_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign byte_class      = out_res.byte_class;
  assign byte_value      = out_res.byte_value;
  assign record_type     = out_res.record_type;
  assign stamp           = out_res.stamp;
  assign decoded_length  = out_res.decoded_length;
  assign length_complete = out_res.length_complete;
  assign end_of_name     = out_res.end_of_name;
  assign end_of_record   = out_res.end_of_record;
  assign bad_length      = out_res.bad_length;

  // A completed length code is always a name or payload length byte.
  a_len_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_complete |->
      (byte_class == rhsp_pkg::CLS_NAME_LEN) || (byte_class == rhsp_pkg::CLS_PAY_LEN))
    else $error("length_complete on a byte that is not a length byte");

  // A rejected length code never completes and reports zero.
  a_bad_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_length |-> !length_complete && (decoded_length == '0))
    else $error("bad_length together with a decoded length");

  // The name ends only on a name byte or on an empty name's length code.
  a_eon_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_name |->
      (byte_class == rhsp_pkg::CLS_NAME) ||
      ((byte_class == rhsp_pkg::CLS_NAME_LEN) && length_complete))
    else $error("end_of_name outside the name field");

  // The record ends only on a payload byte or an empty payload's length code.
  a_eor_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_record |->
      (byte_class == rhsp_pkg::CLS_PAYLOAD) ||
      ((byte_class == rhsp_pkg::CLS_PAY_LEN) && length_complete))
    else $error("end_of_record outside the payload field");

  // A held input item keeps its byte until it moves to the output.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("input register lost or changed a waiting item");

endmodule

`default_nettype wire

### test/record_header_stream_parser_unit_test.sv
// ----------------------------------------------------------------------------
// record_header_stream_parser_unit_test: record header parser testbench
// Feeds byte streams of whole records (names, timestamps, multi-byte and
// over-long length codes, broken length codes) under several mask settings,
// predicts every result item from an in-bench parser model and compares each
// field as items leave the block. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module record_header_stream_parser_unit_test;

  localparam int unsigned MAX_CODE_BYTES = 8;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned PHASE_BYTES    = 40;

  // clock, reset and block ports; every input starts at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [rhsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rhsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] byte_class;
  logic [7:0] byte_value;
  logic [15:0] record_type;
  logic [31:0] stamp;
  logic [rhsp_pkg::DLEN_W-1:0] decoded_length;
  logic length_complete;
  logic end_of_name;
  logic end_of_record;
  logic bad_length;

  record_header_stream_parser_unit uut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_class(byte_class), .byte_value(byte_value), .record_type(record_type),
    .stamp(stamp), .decoded_length(decoded_length),
    .length_complete(length_complete), .end_of_name(end_of_name),
    .end_of_record(end_of_record), .bad_length(bad_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // stream bytes waiting to be offered, and parse reports waiting to arrive
  logic [7:0]        stream_bytes[$];
  rhsp_pkg::result_t byte_reports[$];

  // handshakes seen at the last rising edge, read by the falling-edge drivers
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Parser model: mask copies and parse state, reset values at time zero
  // --------------------------------------------------------------------------
  logic [7:0]       name_mask = rhsp_pkg::NEW_NAME_MASK_RST;
  logic [7:0]       ext_mask  = rhsp_pkg::EXT_MASK_RST;
  rhsp_pkg::phase_t prs_phase = rhsp_pkg::PH_TYPE;
  logic [3:0]       code_left = '0;
  logic [63:0]      code_acc = '0;
  logic [55:0]      field_left = '0;
  logic [15:0]      cur_type = '0;
  logic [31:0]      cur_stamp = '0;
  logic [1:0]       stamp_idx = '0;
  logic             code_is_payload = 1'b0;

  // After the name (or right after the type byte when there is none): the
  // extended test looks at the type with the new-name bits already cleared.
  function void leave_name();
    if ((cur_type & {8'h00, ext_mask}) != 16'h0) begin
      prs_phase = rhsp_pkg::PH_STAMP;
      stamp_idx = '0;
    end else begin
      prs_phase = rhsp_pkg::PH_LEN;
      code_is_payload = 1'b1;
      code_left = '0;
    end
  endfunction

  function rhsp_pkg::result_t parse_byte(input logic [7:0] b);
    rhsp_pkg::result_t r;
    int unsigned n;
    logic [7:0] marker;
    logic done;
    r = '0;
    r.byte_value = b;
    r.byte_class = rhsp_pkg::CLS_TYPE;
    done = 1'b0;
    case (prs_phase)
      rhsp_pkg::PH_LEN: begin
        r.byte_class = code_is_payload ? rhsp_pkg::CLS_PAY_LEN : rhsp_pkg::CLS_NAME_LEN;
        if (code_left == 4'd0) begin
          // leading zeros of the first byte give the count of extra bytes
          n = 1;
          if (b != 8'h00) begin
            while (b[8-n] == 1'b0) n++;
          end
          if (b == 8'h00 || n > MAX_CODE_BYTES) begin
            // broken code: drop back to waiting for a type byte
            r.bad_length = 1'b1;
            prs_phase = rhsp_pkg::PH_TYPE;
            code_acc = '0;
          end else begin
            marker = 8'h80 >> (n - 1);
            code_acc = {56'h0, b & ~marker};
            code_left = 4'(n - 1);
            done = (n == 1);
          end
        end else begin
          code_acc = {code_acc[55:0], b};
          code_left = code_left - 4'd1;
          done = (code_left == 4'd0);
        end
        if (done) begin
          r.length_complete = 1'b1;
          r.decoded_length = code_acc[55:0];
          field_left = code_acc[55:0];
          if (code_is_payload) begin
            if (field_left == '0) begin
              r.end_of_record = 1'b1;
              prs_phase = rhsp_pkg::PH_TYPE;
            end else begin
              prs_phase = rhsp_pkg::PH_PAYLOAD;
            end
          end else if (field_left == '0) begin
            r.end_of_name = 1'b1;
            leave_name();
          end else begin
            prs_phase = rhsp_pkg::PH_NAME;
          end
        end
      end
      rhsp_pkg::PH_NAME: begin
        r.byte_class = rhsp_pkg::CLS_NAME;
        field_left = field_left - 56'd1;
        if (field_left == '0) begin
          r.end_of_name = 1'b1;
          leave_name();
        end
      end
      rhsp_pkg::PH_STAMP: begin
        r.byte_class = rhsp_pkg::CLS_STAMP;
        cur_stamp[stamp_idx*8 +: 8] = b;
        if (stamp_idx == 2'd3) begin
          stamp_idx = '0;
          prs_phase = rhsp_pkg::PH_HIGH;
        end else begin
          stamp_idx = stamp_idx + 2'd1;
        end
      end
      rhsp_pkg::PH_HIGH: begin
        r.byte_class = rhsp_pkg::CLS_HIGH;
        cur_type[15:8] = b;
        prs_phase = rhsp_pkg::PH_LEN;
        code_is_payload = 1'b1;
        code_left = '0;
      end
      rhsp_pkg::PH_PAYLOAD: begin
        r.byte_class = rhsp_pkg::CLS_PAYLOAD;
        field_left = field_left - 56'd1;
        if (field_left == '0) begin
          r.end_of_record = 1'b1;
          prs_phase = rhsp_pkg::PH_TYPE;
        end
      end
      default: begin
        // type byte: high byte cleared, new-name bits stripped if present
        cur_type = {8'h00, b};
        code_left = '0;
        if ((b & name_mask) != 8'h00) begin
          cur_type = {8'h00, b & ~name_mask};
          prs_phase = rhsp_pkg::PH_LEN;
          code_is_payload = 1'b0;
        end else begin
          leave_name();
        end
      end
    endcase
    r.record_type = cur_type;
    r.stamp = cur_stamp;
    return r;
  endfunction

  function void check_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge, predict on input
  // items, compare on output items, and watch for a stuck run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rhsp_pkg::result_t want;
    in_fire = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    if (in_fire) begin
      byte_reports.push_back(parse_byte(data_byte));
    end
    if (out_fire) begin
      reports_seen++;
      if (byte_reports.size() == 0) begin
        $error("result item with no byte outstanding: value %0h", byte_value);
        mismatches++;
      end else begin
        want = byte_reports.pop_front();
        check_field("byte_class", 64'(want.byte_class), 64'(byte_class));
        check_field("byte_value", 64'(want.byte_value), 64'(byte_value));
        check_field("record_type", 64'(want.record_type), 64'(record_type));
        check_field("stamp", 64'(want.stamp), 64'(stamp));
        check_field("decoded_length", 64'(want.decoded_length), 64'(decoded_length));
        check_field("length_complete", 64'(want.length_complete), 64'(length_complete));
        check_field("end_of_name", 64'(want.end_of_name), 64'(end_of_name));
        check_field("end_of_record", 64'(want.end_of_record), 64'(end_of_record));
        check_field("bad_length", 64'(want.bad_length), 64'(bad_length));
      end
    end
    // a long quiet stretch means the block has hung
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle draw: no gap while a side is in a steady burst, else a random gap.
  function int unsigned draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer stream bytes at the falling edge; hold valid and the byte
  // until the item is taken, then wait a drawn gap before the next one.
  // --------------------------------------------------------------------------
  bit tx_busy = 1'b0;
  bit tx_steady = 1'b0;
  int unsigned tx_gap = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        tx_busy = 1'b0;
        if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
        tx_gap = draw_gap(tx_steady);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (stream_bytes.size() > 0) begin
          data_byte <= stream_bytes.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_valid <= tx_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: drop ready for a drawn stall after each result item; once in
  // the run, with plenty of bytes still queued, hold off for a long stretch
  // so the block fills and stalls input.
  // --------------------------------------------------------------------------
  bit rx_steady = 1'b0;
  bit rx_held = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) begin
        if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
        rx_gap = draw_gap(rx_steady);
        if (!rx_held && reports_seen >= 150 && stream_bytes.size() >= 8) begin
          rx_hold = 120;
          rx_held = 1'b1;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Wait until every byte has been taken and every report has come back.
  task automatic drain();
    while (stream_bytes.size() != 0 || tx_busy || byte_reports.size() != 0)
      @(negedge clk);
  endtask

  // Write one mask register; only called while the block is drained.
  task automatic write_reg(input logic [rhsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == rhsp_pkg::REG_NEW_NAME_MASK) name_mask = value;
    else ext_mask = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Mostly tiny fields, now and then one long enough for a two-byte code.
  function int unsigned pick_len();
    return ($urandom_range(0, 59) == 0) ? $urandom_range(128, 200)
                                         : $urandom_range(0, 6);
  endfunction

  // Emit a length code, sometimes padded out to a longer than needed form.
  task automatic add_length(input int unsigned value);
    int unsigned n;
    logic [63:0] code;
    int i;
    n = (value < 128) ? 1 : 2;
    if ($urandom_range(0, 2) == 0) n = $urandom_range(n, MAX_CODE_BYTES);
    code = (64'd1 << (7 * n)) | 64'(value);
    for (i = n - 1; i >= 0; i--) stream_bytes.push_back(code[8*i +: 8]);
  endtask

  // One record with random content; about one in eight is cut short by a
  // zero first length byte, after which the parser expects a new type byte.
  task automatic add_record();
    logic [7:0] kind;
    logic [7:0] flat;
    bit has_name;
    bit has_ext;
    bit broken;
    int unsigned len;
    broken = ($urandom_range(0, 7) == 0);
    kind = 8'($urandom_range(0, 255));
    stream_bytes.push_back(kind);
    has_name = (kind & name_mask) != 8'h00;
    flat = has_name ? (kind & ~name_mask) : kind;
    has_ext = (flat & ext_mask) != 8'h00;
    if (has_name) begin
      if (broken && $urandom_range(0, 1) == 1) begin
        stream_bytes.push_back(8'h00);
        return;
      end
      len = pick_len();
      add_length(len);
      repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // four timestamp bytes and the high type byte
    if (has_ext) repeat (5) stream_bytes.push_back(8'($urandom_range(0, 255)));
    if (broken) begin
      stream_bytes.push_back(8'h00);
      return;
    end
    len = pick_len();
    add_length(len);
    repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  logic [7:0] directed_bytes[23] = '{
    // plain type, empty payload
    8'h00, 8'h80,
    // name flag plus extended: empty name, timestamp, high type, 2-byte code
    8'h03, 8'h80, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h40, 8'h02, 8'h11, 8'hEE,
    // all type bits set, zero first byte in the name length
    8'hFF, 8'h00,
    // one-byte name, zero first byte in the payload length
    8'h01, 8'h81, 8'hFF, 8'h00,
    // no timestamp: the last one is kept; two payload bytes at the extremes
    8'h00, 8'h82, 8'h00, 8'hFF
  };
  logic [7:0] name_setting[7] = '{8'hFF, 8'h00, 8'h03, 8'h80, 8'h00, 8'h00, 8'h01};
  logic [7:0] ext_setting[7]  = '{8'h00, 8'hFF, 8'h02, 8'h40, 8'h00, 8'h00, 8'h02};

  initial begin
    int unsigned start_count;
    // two of the settings take random masks
    name_setting[4] = 8'($urandom_range(0, 255));
    ext_setting[4]  = 8'($urandom_range(0, 255));
    name_setting[5] = 8'($urandom_range(0, 255));
    ext_setting[5]  = 8'($urandom_range(0, 255));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed bytes under the reset masks
    foreach (directed_bytes[k]) stream_bytes.push_back(directed_bytes[k]);
    drain();

    // random records under each mask setting
    foreach (name_setting[p]) begin
      write_reg(rhsp_pkg::REG_NEW_NAME_MASK, name_setting[p]);
      write_reg(rhsp_pkg::REG_EXT_MASK, ext_setting[p]);
      start_count = stream_bytes.size();
      while (stream_bytes.size() - start_count < PHASE_BYTES) add_record();
      drain();
    end

    // largest length code: eight bytes, all value bits set; the payload never
    // ends, so this goes last
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    repeat (7) stream_bytes.push_back(8'hFF);
    repeat (5) stream_bytes.push_back(8'($urandom_range(0, 255)));
    drain();

    // let any stray result item show up
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
